// ----- hw/rtl/swbd_pkg.sv -----
// Shared types and constants for the sliding window burst detector.
package swbd_pkg;

  localparam int TS_W  = 32;
  localparam int WIN_W = 31;
  localparam int THR_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 4'd5;
  localparam logic [WIN_W-1:0] WINDOW_RST    = 31'd1000;

  typedef struct packed {
    logic take;
    logic issue;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic issue_done;
  } dp_sts_t;

endpackage

// ----- hw/rtl/swbd_ctrl.sv -----
// Controller state machine for the burst detector: handshakes and scan sequencing.
module swbd_ctrl
  import swbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.issue_done) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken word");

  a_take_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == ST_SCAN && !in_ready))
    else $error("accepted word did not start a scan");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("result not presented after load");

endmodule

// ----- hw/rtl/swbd_dpath.sv -----
// Datapath for the burst detector: stamp ring, configuration and window counter.
module swbd_dpath
  import swbd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [TS_W-1:0]      in_timestamp_ms,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_data,
  output logic                 out_burst_flag
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CW   = AW + 1;
  localparam int CAPW = (CW > THR_W + 1) ? CW : THR_W + 1;

  logic [TS_W-1:0]  ring_mem [RING_DEPTH];
  logic [THR_W-1:0] thr_r;
  logic [WIN_W-1:0] win_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    cnt_r;
  logic [TS_W-1:0]  now_r;
  logic [TS_W-1:0]  rd_data_r;
  logic             rd_vld_r;
  logic             flag_r;

  logic [CAPW-1:0]  thr_plus;
  logic [CW-1:0]    cap;
  logic             ring_full;
  logic [AW-1:0]    wr_idx;
  logic [TS_W-1:0]  age;
  logic             in_window;

  assign thr_plus  = CAPW'(thr_r) + CAPW'(1);
  assign cap       = (thr_plus > CAPW'(RING_DEPTH)) ? CW'(RING_DEPTH) : thr_plus[CW-1:0];
  assign ring_full = (fill_r >= cap);
  assign wr_idx    = ring_full ? head_r : fill_r[AW-1:0];
  assign age       = now_r - rd_data_r;
  assign in_window = (age <= {1'b0, win_r});

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (ring_full) begin
      head_nxt = ({1'b0, head_r} == cap - CW'(1)) ? '0 : head_r + AW'(1);
    end else begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ring_mem[wr_idx] <= in_timestamp_ms;
    end
    if (cmd.issue) begin
      rd_data_r <= ring_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RST;
      win_r    <= WINDOW_RST;
      head_r   <= '0;
      fill_r   <= '0;
      idx_r    <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: begin
            thr_r  <= cfg_data[THR_W-1:0];
            head_r <= '0;
            fill_r <= '0;
          end
          REG_WINDOW: win_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
        idx_r  <= '0;
        cnt_r  <= '0;
      end
      if (cmd.issue) begin
        idx_r <= idx_r + CW'(1);
      end
      if (rd_vld_r && in_window) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      now_r <= in_timestamp_ms;
    end
    if (cmd.emit) begin
      flag_r <= (CAPW'(cnt_r) >= CAPW'(thr_r));
    end
  end

  assign sts.issue_done = (idx_r == fill_r);
  assign out_burst_flag = flag_r;

  a_fill_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap)
    else $error("ring fill beyond capacity");

  a_head_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < cap) |-> (head_r == '0))
    else $error("ring head moved before ring filled");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (idx_r < fill_r))
    else $error("scan read beyond stored words");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (fill_r != '0))
    else $error("stored word not counted in fill");

endmodule

// ----- hw/rtl/sliding_window_burst_detector.sv -----
// Top level of the sliding window burst detector: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_timestamp_ms[31:0]
//   out      output     out_valid / out_ready out_burst_flag
//   cfg      input      cfg_valid / cfg_ready cfg_index[0], cfg_data[30:0]
//
// After a word is accepted, all stored stamps, the new one included, are read one per cycle
// through the single port of the ring; the next word is taken only once the result is loaded
// into the result register, which needs that register to be free.
// Reset is synchronous and clears the ring to empty and the registers to 5 and 1000.
// A waiting result blocks the loading of the next result, and with it the next input.
// Writing the threshold register empties the ring; cfg_ready is always high.
module sliding_window_burst_detector
  import swbd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TS_W-1:0]      in_timestamp_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_burst_flag,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  swbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swbd_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_timestamp_ms (in_timestamp_ms),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_burst_flag  (out_burst_flag)
  );

endmodule

// ----- tb/swbd_checker.sv -----
// Checker that predicts and compares burst flags for the sliding window burst detector.
`timescale 1ns / 1ps

module swbd_checker
  import swbd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [TS_W-1:0]      in_timestamp_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_burst_flag,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  logic [TS_W-1:0]  stamps [RING_DEPTH];
  int unsigned      head;
  int unsigned      fill;
  logic [THR_W-1:0] threshold;
  logic [WIN_W-1:0] window;
  bit               pending_flags [$];
  bit               want_flag;

  function automatic bit store_stamp_and_flag(logic [TS_W-1:0] now);
    int unsigned     cap;
    int unsigned     hits;
    logic [TS_W-1:0] age;
    cap  = (int'(threshold) + 1 > RING_DEPTH) ? RING_DEPTH : int'(threshold) + 1;
    hits = 0;
    stamps[(head + fill) % cap] = now;
    if (fill < cap) begin
      fill++;
    end else begin
      head = (head + 1) % cap;
    end
    if (fill < threshold) begin
      return 1'b0;
    end
    for (int i = 0; i < fill; i++) begin
      age = now - stamps[(head + i) % cap];
      if (age <= {1'b0, window}) begin
        hits++;
      end
    end
    return hits >= threshold;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head       = 0;
      fill       = 0;
      threshold  = THRESHOLD_RST;
      window     = WINDOW_RST;
      mismatches = 0;
      pending_flags.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD) begin
          threshold = cfg_data[THR_W-1:0];
          head      = 0;
          fill      = 0;
        end else if (cfg_index == REG_WINDOW) begin
          window = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        pending_flags.push_back(store_stamp_and_flag(in_timestamp_ms));
      end
      if (out_valid && out_ready) begin
        if (pending_flags.size() == 0) begin
          $error("burst_flag: expected no word, actual %0b", out_burst_flag);
          mismatches++;
        end else begin
          want_flag = pending_flags.pop_front();
          if (out_burst_flag !== want_flag) begin
            $error("burst_flag: expected %0b, actual %0b", want_flag, out_burst_flag);
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_flags.size();
  end

endmodule

// ----- tb/sliding_window_burst_detector_tb.sv -----
// Testbench top that drives stimulus into the sliding window burst detector and reports the verdict.
`timescale 1ns / 1ps

module sliding_window_burst_detector_tb;
  import swbd_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 50;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [TS_W-1:0]      in_timestamp_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_burst_flag;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIN_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;

  bit          in_idle;
  bit          out_idle;
  int unsigned words_sent;
  int unsigned cfg_writes;
  int unsigned cycles;

  sliding_window_burst_detector #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_timestamp_ms(in_timestamp_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_burst_flag(out_burst_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  swbd_checker #(.RING_DEPTH(RING_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_timestamp_ms(in_timestamp_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_burst_flag(out_burst_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d words outstanding", cycles, outstanding);
    $display("sliding_window_burst_detector regression: fail");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Returns at the rising edge where the word is accepted; valid stays up until the next call.
  task automatic send_word(logic [TS_W-1:0] stamp);
    @(negedge clk);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_timestamp_ms <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (RING_DEPTH + 3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int unsigned      thr;
    int unsigned      pick;
    logic [WIN_W-1:0] win;
    logic [TS_W-1:0]  now_ms;
    logic [TS_W-1:0]  step_lim;
    longint unsigned  span;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_timestamp_ms = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_THRESHOLD;
    cfg_data        = '0;
    in_idle         = 1'b1;
    out_idle        = 1'b1;
    words_sent      = 0;
    cfg_writes      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a burst forms on the fifth word, then the ring overwrites and wraps.
    send_word(32'd0);
    send_word(32'd100);
    send_word(32'd200);
    send_word(32'd300);
    send_word(32'd400);
    send_word(32'd1400);
    send_word(32'hFFFF_FFF0);
    send_word(32'h0000_0010);
    send_word(32'hFFFF_FFFF);

    // A threshold of zero flags every word.
    drain_results();
    write_reg(REG_THRESHOLD, 31'h7FFF_FFF0);
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);

    // A zero window counts only identical stamps.
    drain_results();
    write_reg(REG_WINDOW, 31'd0);
    write_reg(REG_THRESHOLD, 31'd2);
    send_word(32'd7);
    send_word(32'd7);
    send_word(32'd8);

    // The widest window, with a stamp that lies in the future of the newest one.
    drain_results();
    write_reg(REG_WINDOW, 31'h7FFF_FFFF);
    write_reg(REG_THRESHOLD, 31'd2);
    send_word(32'd500);
    send_word(32'd400);
    send_word(32'h8000_0190);

    thr = 2;
    win = 31'h7FFF_FFFF;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      in_idle  = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      out_idle = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (phase < 3 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0:       win = 31'd0;
          1:       win = 31'h7FFF_FFFF;
          2:       win = WIN_W'($urandom_range(1, 64));
          3:       win = WIN_W'($urandom_range(100, 5000));
          default: win = WIN_W'($urandom);
        endcase
        write_reg(REG_WINDOW, win);
      end
      if (phase < 3 || $urandom_range(0, 3) != 0) begin
        case (phase)
          0:       thr = 15;
          1:       thr = 1;
          2:       thr = 0;
          default: thr = $urandom_range(0, 15);
        endcase
        write_reg(REG_THRESHOLD, WIN_W'(($urandom & 32'h7FFF_FFF0) | thr));
      end
      now_ms = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4000);
      span   = 2 * longint'(win) / (thr + 1) + 1;
      step_lim = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      for (int item = 0; item < PHASE_WORDS; item++) begin
        if (phase == 3 && item == PHASE_WORDS / 2) begin
          drain_results();
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          send_word($urandom);
        end else if (pick == 1) begin
          send_word(now_ms - $urandom_range(1, 1000));
        end else begin
          if (pick == 2) begin
            now_ms = now_ms + win + $urandom_range(0, 1);
          end else begin
            now_ms = now_ms + $urandom_range(0, step_lim);
          end
          send_word(now_ms);
        end
      end
    end

    drain_results();
    $display("covered %0d event words and %0d register writes over %0d random phases",
             words_sent, cfg_writes, PHASES);
    $display("thresholds from 0 to 15, windows from 0 to the widest, stamps across the wrap");
    if (mismatches == 0 && outstanding == 0) begin
      $display("sliding_window_burst_detector regression: pass");
    end else begin
      $display("sliding_window_burst_detector regression: fail");
    end
    $finish;
  end

endmodule
